FILE: sv/bce_pkg.sv
// Package for the byte-stream emitter with word-sum checksum.
// Holds operation codes, status codes and opcode encoding constants.
// No dependencies.
package bce_pkg;

    typedef enum logic [2:0] {
        OP_BYTE    = 3'd0,
        OP_WORD    = 3'd1,
        OP_LONG    = 3'd2,
        OP_QUAD    = 3'd3,
        OP_OPCODE  = 3'd4,
        OP_MODE    = 3'd5,
        OP_OPERAND = 3'd6,
        OP_UNUSED  = 3'd7
    } t_op;

    typedef enum logic {
        ST_OK        = 1'b0,
        ST_OPC_RANGE = 1'b1
    } t_status;

    localparam logic [63:0] OPC_SHORT_LIMIT = 64'h80;
    localparam logic [63:0] OPC_LONG_LIMIT  = 64'h4000;
    localparam logic [15:0] OPC_LONG_BASE   = 16'h8000;

    localparam int unsigned MAX_BYTES = 8;

endpackage

FILE: sv/bytecode_emitter_with_checksum.sv
// Byte-stream emitter: serialises items big-endian and keeps a word-sum checksum.
// Depends on bce_pkg for operation codes, status codes and opcode constants.
//
// An item is decoded as it is accepted into a byte shift register, which then
// sends one byte beat per cycle into the output register while the output is
// not stalled; an item produces 1, 2, 4 or 8 bytes, a single beat on an error,
// or no beat at all. The next item is accepted in the cycle its predecessor's
// last beat moves to the output register, so the emitter does not take a new
// item while it still holds bytes of the last one.
// Addressing-mode packing state changes at accept time; checksum and offset
// advance as each data byte, but not an error beat, enters the output register.
module bytecode_emitter_with_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_value,
    input  logic [3:0]  i_addr_mode,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_data_byte,
    output logic [0:0]  o_status,
    output logic        o_last_of_run,
    output logic [31:0] o_running_sum,
    output logic [31:0] o_byte_offset
);

    logic        r_busy;
    logic [63:0] r_data;
    logic [3:0]  r_left;
    logic        r_err;

    logic [31:0] r_sum_acc;
    logic [31:0] r_bytes_written;
    logic        r_mode_pending;
    logic [3:0]  r_held_mode;

    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_status;
    logic        r_out_last;
    logic [31:0] r_out_sum;
    logic [31:0] r_out_off;

    logic        advance;
    logic        accept;
    logic [63:0] n_data;
    logic [3:0]  n_len;
    logic        n_err;
    logic        n_mode_pending;
    logic [3:0]  n_held_mode;
    logic [7:0]  cur_byte;
    logic [31:0] sum_add;
    logic [15:0] opc_long;

    assign advance  = r_busy && (!r_out_valid || i_ready);
    assign o_ready  = !r_busy || (advance && (r_left == 4'd1));
    assign accept   = i_valid && o_ready;
    assign cur_byte = r_data[63:56];
    assign opc_long = bce_pkg::OPC_LONG_BASE + i_value[15:0];

    always_comb begin
        unique case (r_bytes_written[1:0])
            2'd0:    sum_add = {cur_byte, 24'd0};
            2'd1:    sum_add = {8'd0, cur_byte, 16'd0};
            2'd2:    sum_add = {16'd0, cur_byte, 8'd0};
            default: sum_add = {24'd0, cur_byte};
        endcase
    end

    always_comb begin
        n_data         = 64'd0;
        n_len          = 4'd0;
        n_err          = 1'b0;
        n_mode_pending = r_mode_pending;
        n_held_mode    = r_held_mode;
        unique case (bce_pkg::t_op'(i_operation))
            bce_pkg::OP_BYTE: begin
                n_data = {i_value[7:0], 56'd0};
                n_len  = 4'd1;
            end
            bce_pkg::OP_WORD: begin
                n_data = {i_value[15:0], 48'd0};
                n_len  = 4'd2;
            end
            bce_pkg::OP_LONG: begin
                n_data = {i_value[31:0], 32'd0};
                n_len  = 4'd4;
            end
            bce_pkg::OP_QUAD: begin
                n_data = i_value;
                n_len  = 4'd8;
            end
            bce_pkg::OP_OPCODE: begin
                n_mode_pending = 1'b0;
                priority if (i_value < bce_pkg::OPC_SHORT_LIMIT) begin
                    n_data = {i_value[7:0], 56'd0};
                    n_len  = 4'd1;
                end else if (i_value < bce_pkg::OPC_LONG_LIMIT) begin
                    n_data = {opc_long, 48'd0};
                    n_len  = 4'd2;
                end else begin
                    n_len  = 4'd1;
                    n_err  = 1'b1;
                end
            end
            bce_pkg::OP_MODE: begin
                if (r_mode_pending) begin
                    n_data         = {i_addr_mode, r_held_mode, 56'd0};
                    n_len          = 4'd1;
                    n_mode_pending = 1'b0;
                end else begin
                    n_held_mode    = i_addr_mode;
                    n_mode_pending = 1'b1;
                end
            end
            bce_pkg::OP_OPERAND: begin
                if (r_mode_pending) begin
                    n_data = {4'd0, r_held_mode, 56'd0};
                    n_len  = 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_left          <= 4'd0;
            r_err           <= 1'b0;
            r_sum_acc       <= 32'd0;
            r_bytes_written <= 32'd0;
            r_mode_pending  <= 1'b0;
            r_held_mode     <= 4'd0;
            r_out_valid     <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_out_last  <= (r_left == 4'd1);
                r_out_off   <= r_bytes_written;
                if (r_err) begin
                    r_out_data   <= 8'd0;
                    r_out_status <= bce_pkg::ST_OPC_RANGE;
                    r_out_sum    <= r_sum_acc;
                end else begin
                    r_out_data      <= cur_byte;
                    r_out_status    <= bce_pkg::ST_OK;
                    r_out_sum       <= r_sum_acc + sum_add;
                    r_sum_acc       <= r_sum_acc + sum_add;
                    r_bytes_written <= r_bytes_written + 32'd1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept && (n_len != 4'd0)) begin
                r_busy <= 1'b1;
                r_data <= n_data;
                r_left <= n_len;
                r_err  <= n_err;
            end else if (advance) begin
                r_data <= {r_data[55:0], 8'd0};
                r_left <= r_left - 4'd1;
                if (r_left == 4'd1) begin
                    r_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_mode_pending <= n_mode_pending;
                r_held_mode    <= n_held_mode;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_data_byte   = r_out_data;
    assign o_status      = r_out_status;
    assign o_last_of_run = r_out_last;
    assign o_running_sum = r_out_sum;
    assign o_byte_offset = r_out_off;

    a_err_beat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == bce_pkg::ST_OPC_RANGE)
            |-> (o_last_of_run && o_data_byte == 8'd0))
        else $error("error beat must be a last beat with zero byte");

    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_err) |=> (r_bytes_written == $past(r_bytes_written) + 32'd1))
        else $error("byte offset must advance by one per emitted byte");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != 4'd0 && r_left <= 4'(bce_pkg::MAX_BYTES)))
        else $error("byte count out of range while busy");

    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> (r_sum_acc == $past(r_sum_acc)))
        else $error("checksum changed without a byte beat");

endmodule
